/* hw/rtl/clbs_pkg.sv */
// ----------------------------------------------------------------------------
// clbs_pkg
// Shared types and constants for the character LCD bus sequencer.
// ----------------------------------------------------------------------------
package clbs_pkg;

  // command codes carried by each input transaction
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_INIT  = 2'd1,
    CMD_GOTO  = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_t;

  // pin sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_RD_SETUP    = 4'd1,
    PH_RD_E1       = 4'd2,
    PH_RD_E2       = 4'd3,
    PH_RD_END_BUSY = 4'd4,
    PH_RD_END_FREE = 4'd5,
    PH_WAIT_PRE    = 4'd6,
    PH_WR_SETUP    = 4'd7,
    PH_WR_E        = 4'd8,
    PH_WR_HOLD     = 4'd9,
    PH_WAIT_POST   = 4'd10
  } phase_t;

  // configuration register indexes
  localparam logic [2:0] REG_BUSY_CLEAR_WAIT = 3'd0;
  localparam logic [2:0] REG_COMMAND_SETTLE  = 3'd1;
  localparam logic [2:0] REG_CHAR_SETTLE     = 3'd2;
  localparam logic [2:0] REG_CLEAR_SETTLE    = 3'd3;
  localparam logic [2:0] REG_FUNCTION_SET    = 3'd4;
  localparam logic [2:0] REG_DISPLAY_CONTROL = 3'd5;
  localparam logic [2:0] REG_ENTRY_MODE      = 3'd6;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned ADDR_W      = 7;

  // register reset values
  localparam logic [15:0] BUSY_CLEAR_WAIT_RST = 16'd32;
  localparam logic [15:0] COMMAND_SETTLE_RST  = 16'd156;
  localparam logic [15:0] CHAR_SETTLE_RST     = 16'd172;
  localparam logic [15:0] CLEAR_SETTLE_RST    = 16'd8000;
  localparam logic [7:0]  FUNCTION_SET_RST    = 8'h38;
  localparam logic [7:0]  DISPLAY_CONTROL_RST = 8'h0F;
  localparam logic [7:0]  ENTRY_MODE_RST      = 8'h06;

  localparam logic [7:0] CLEAR_DISPLAY_BYTE = 8'h01;
  localparam logic       SET_DDRAM_BIT      = 1'b1;
  localparam int unsigned BUSY_BIT          = 7;
  localparam logic [1:0] ROW_SECOND         = 2'd2;

  // init sequence steps
  localparam logic [2:0] STEP_NONE     = 3'd0;
  localparam logic [2:0] STEP_FUNCTION = 3'd1;
  localparam logic [2:0] STEP_DISPLAY  = 3'd2;
  localparam logic [2:0] STEP_CLEAR    = 3'd3;

  // classified item between front and back
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] cmd_byte;
    logic [7:0] din;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic       pin_enable;
    logic       pin_register_select;
    logic       pin_read_write;
    logic [7:0] pin_data_out;
    logic       data_drive;
    logic       ready_res;
    logic       rejected;
  } res_t;

endpackage

/* hw/rtl/clbs_queue.sv */
// ----------------------------------------------------------------------------
// clbs_queue
// Two-entry register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module clbs_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push_ok;
  logic             pop_ok;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign push_ok  = push && !full;
  assign pop_ok   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push_ok, pop_ok})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/clbs_front.sv */
// ----------------------------------------------------------------------------
// clbs_front
// Classifies an incoming transaction and forms the byte it will write.
// ----------------------------------------------------------------------------
module clbs_front import clbs_pkg::*; #(
  parameter int unsigned SECOND_ROW_BASE = 64
) (
  input  logic [1:0] cmd,
  input  logic [7:0] char_code,
  input  logic [5:0] column,
  input  logic [1:0] row,
  input  logic [7:0] pin_data_in,
  output item_t      item
);

  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] addr;

  // column is one based; adding all ones subtracts one modulo 128
  assign row_base = (row == ROW_SECOND) ? ADDR_W'(SECOND_ROW_BASE) : '0;
  assign addr     = ADDR_W'(column) + {ADDR_W{1'b1}} + row_base;

  always_comb begin
    item.cmd = cmd_t'(cmd);
    item.din = pin_data_in;
    if (cmd_t'(cmd) == CMD_GOTO) begin
      item.cmd_byte = {SET_DDRAM_BIT, addr};
    end else begin
      item.cmd_byte = char_code;
    end
  end

endmodule

/* hw/rtl/clbs_engine.sv */
// ----------------------------------------------------------------------------
// clbs_engine
// Pin sequencer: one tick per item, status polling, byte writes and waits.
// ----------------------------------------------------------------------------
module clbs_engine import clbs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  item_t                  item,
  input  logic                   item_empty,
  output logic                   item_pop,
  output res_t                   res,
  output logic                   res_push,
  input  logic                   res_full
);

  logic [15:0] busy_clear_wait;
  logic [15:0] command_settle;
  logic [15:0] char_settle;
  logic [15:0] clear_settle;
  logic [7:0]  function_set;
  logic [7:0]  display_control;
  logic [7:0]  entry_mode;

  phase_t      phase, phase_next;
  logic [15:0] wait_count, wait_count_next;
  logic [2:0]  init_step, init_step_next;
  logic [7:0]  pending_byte, pending_byte_next;
  logic        pending_is_data, pending_is_data_next;
  logic        pin_e, pin_e_next;
  logic        pin_rs, pin_rs_next;
  logic        pin_rw, pin_rw_next;
  logic [7:0]  pin_data, pin_data_next;
  logic        pin_drive, pin_drive_next;
  logic        rejected;
  logic        step;

  assign step     = !item_empty && !res_full;
  assign item_pop = step;
  assign res_push = step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_clear_wait <= BUSY_CLEAR_WAIT_RST;
      command_settle  <= COMMAND_SETTLE_RST;
      char_settle     <= CHAR_SETTLE_RST;
      clear_settle    <= CLEAR_SETTLE_RST;
      function_set    <= FUNCTION_SET_RST;
      display_control <= DISPLAY_CONTROL_RST;
      entry_mode      <= ENTRY_MODE_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_BUSY_CLEAR_WAIT: busy_clear_wait <= cfg_data;
        REG_COMMAND_SETTLE:  command_settle  <= cfg_data;
        REG_CHAR_SETTLE:     char_settle     <= cfg_data;
        REG_CLEAR_SETTLE:    clear_settle    <= cfg_data;
        REG_FUNCTION_SET:    function_set    <= cfg_data[7:0];
        REG_DISPLAY_CONTROL: display_control <= cfg_data[7:0];
        REG_ENTRY_MODE:      entry_mode      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      wait_count      <= '0;
      init_step       <= STEP_NONE;
      pending_byte    <= '0;
      pending_is_data <= 1'b0;
      pin_e           <= 1'b0;
      pin_rs          <= 1'b0;
      pin_rw          <= 1'b0;
      pin_data        <= '0;
      pin_drive       <= 1'b1;
    end else if (step) begin
      phase           <= phase_next;
      wait_count      <= wait_count_next;
      init_step       <= init_step_next;
      pending_byte    <= pending_byte_next;
      pending_is_data <= pending_is_data_next;
      pin_e           <= pin_e_next;
      pin_rs          <= pin_rs_next;
      pin_rw          <= pin_rw_next;
      pin_data        <= pin_data_next;
      pin_drive       <= pin_drive_next;
    end
  end

  always_comb begin
    logic        settle_done;
    logic        go_settle;
    logic [15:0] settle_n;
    phase_next           = phase;
    wait_count_next      = wait_count;
    init_step_next       = init_step;
    pending_byte_next    = pending_byte;
    pending_is_data_next = pending_is_data;
    pin_e_next           = pin_e;
    pin_rs_next          = pin_rs;
    pin_rw_next          = pin_rw;
    pin_data_next        = pin_data;
    pin_drive_next       = pin_drive;
    rejected             = 1'b0;
    settle_done          = 1'b0;
    go_settle            = 1'b0;
    settle_n             = '0;

    // command start, only from idle
    if (item.cmd != CMD_TICK) begin
      if (phase != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        case (item.cmd)
          CMD_INIT: begin
            init_step_next       = STEP_FUNCTION;
            pending_byte_next    = function_set;
            pending_is_data_next = 1'b0;
            phase_next           = PH_RD_SETUP;
          end
          CMD_GOTO: begin
            init_step_next       = STEP_NONE;
            pending_byte_next    = item.cmd_byte;
            pending_is_data_next = 1'b0;
            phase_next           = PH_WR_SETUP;
          end
          default: begin
            init_step_next       = STEP_NONE;
            pending_byte_next    = item.cmd_byte;
            pending_is_data_next = 1'b1;
            phase_next           = PH_RD_SETUP;
          end
        endcase
      end
    end

    // one tick of the pin sequence
    case (phase_next)
      PH_RD_SETUP: begin
        pin_e_next = 1'b0; pin_rs_next = 1'b0; pin_rw_next = 1'b1; pin_drive_next = 1'b0;
        phase_next = PH_RD_E1;
      end
      PH_RD_E1: begin
        pin_e_next = 1'b1; pin_rs_next = 1'b0; pin_rw_next = 1'b1; pin_drive_next = 1'b0;
        phase_next = PH_RD_E2;
      end
      PH_RD_E2: begin
        pin_e_next = 1'b1; pin_rs_next = 1'b0; pin_rw_next = 1'b1; pin_drive_next = 1'b0;
        phase_next = item.din[BUSY_BIT] ? PH_RD_END_BUSY : PH_RD_END_FREE;
      end
      PH_RD_END_BUSY: begin
        pin_e_next = 1'b0; pin_rs_next = 1'b0; pin_rw_next = 1'b1; pin_drive_next = 1'b1;
        phase_next = PH_RD_SETUP;
      end
      PH_RD_END_FREE: begin
        pin_e_next = 1'b0; pin_rs_next = 1'b0; pin_rw_next = 1'b1; pin_drive_next = 1'b1;
        if (busy_clear_wait == '0) begin
          phase_next = PH_WR_SETUP;
        end else begin
          wait_count_next = busy_clear_wait;
          phase_next      = PH_WAIT_PRE;
        end
      end
      PH_WAIT_PRE: begin
        wait_count_next = wait_count_next - 16'd1;
        if (wait_count_next == '0) begin
          phase_next = PH_WR_SETUP;
        end
      end
      PH_WR_SETUP: begin
        pin_data_next = pending_byte_next;
        pin_e_next = 1'b0; pin_rs_next = pending_is_data_next; pin_rw_next = 1'b0;
        pin_drive_next = 1'b1;
        phase_next = PH_WR_E;
      end
      PH_WR_E: begin
        pin_e_next = 1'b1; pin_rs_next = pending_is_data_next; pin_rw_next = 1'b0;
        pin_drive_next = 1'b1;
        phase_next = PH_WR_HOLD;
      end
      PH_WR_HOLD: begin
        pin_e_next = 1'b0; pin_rs_next = pending_is_data_next; pin_rw_next = 1'b0;
        pin_drive_next = 1'b1;
        if (pending_is_data_next) begin
          settle_n  = char_settle;
          go_settle = 1'b1;
        end else if (init_step_next == STEP_CLEAR) begin
          settle_n  = clear_settle;
          go_settle = 1'b1;
        end else if (init_step_next != STEP_NONE) begin
          settle_n  = command_settle;
          go_settle = 1'b1;
        end else begin
          phase_next = PH_IDLE;
        end
        if (go_settle) begin
          if (settle_n == '0) begin
            settle_done = 1'b1;
          end else begin
            wait_count_next = settle_n;
            phase_next      = PH_WAIT_POST;
          end
        end
      end
      PH_WAIT_POST: begin
        wait_count_next = wait_count_next - 16'd1;
        if (wait_count_next == '0) begin
          settle_done = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    // next init command, or back to idle
    if (settle_done) begin
      if (init_step_next >= STEP_FUNCTION && init_step_next <= STEP_CLEAR) begin
        init_step_next       = init_step_next + 3'd1;
        pending_is_data_next = 1'b0;
        phase_next           = PH_WR_SETUP;
        case (init_step_next)
          STEP_DISPLAY: pending_byte_next = display_control;
          STEP_CLEAR:   pending_byte_next = CLEAR_DISPLAY_BYTE;
          default:      pending_byte_next = entry_mode;
        endcase
      end else begin
        init_step_next = STEP_NONE;
        phase_next     = PH_IDLE;
      end
    end
  end

  always_comb begin
    res.pin_enable          = pin_e_next;
    res.pin_register_select = pin_rs_next;
    res.pin_read_write      = pin_rw_next;
    res.pin_data_out        = pin_data_next;
    res.data_drive          = pin_drive_next;
    res.ready_res           = (phase_next == PH_IDLE);
    res.rejected            = rejected;
  end

endmodule

/* hw/rtl/char_lcd_bus_sequencer.sv */
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer
// Character LCD 8-bit bus sequencer: one transaction is one 250 ns tick,
// optionally carrying an init, goto or write character command.
// ----------------------------------------------------------------------------
// path: a transaction is written into the input queue at the accepting edge; the
//   sequencer then steps on it and writes its result into the result queue, and
//   it stalls while the input queue is empty or the result queue is full
// throughput: one transaction per cycle while the result queue is not full; the pin
//   sequencer steps once per transaction between the two two-entry queues
// reset (rst, synchronous): queues empty, sequencer idle, pins low with the
//   data bus driven, all registers at their defaults
module char_lcd_bus_sequencer import clbs_pkg::*; #(
  parameter int unsigned SECOND_ROW_BASE = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration writes
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input side
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             cmd,
  input  logic [7:0]             char_code,
  input  logic [5:0]             column,
  input  logic [1:0]             row,
  input  logic [7:0]             pin_data_in,
  // result side
  output logic                   empty,
  input  logic                   pop,
  output logic                   pin_enable,
  output logic                   pin_register_select,
  output logic                   pin_read_write,
  output logic [7:0]             pin_data_out,
  output logic                   data_drive,
  output logic                   ready_res,
  output logic                   rejected
);

  item_t front_item;
  item_t queued_item;
  logic  item_empty;
  logic  item_pop;
  res_t  engine_res;
  res_t  head_res;
  logic  res_push;
  logic  res_full;

  // front: decode the command and build the goto address byte
  clbs_front #(
    .SECOND_ROW_BASE(SECOND_ROW_BASE)
  ) u_front (
    .cmd        (cmd),
    .char_code  (char_code),
    .column     (column),
    .row        (row),
    .pin_data_in(pin_data_in),
    .item       (front_item)
  );

  // classified transactions waiting for the sequencer
  clbs_queue #(
    .WIDTH($bits(item_t))
  ) u_item_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(front_item),
    .full     (full),
    .pop      (item_pop),
    .pop_data (queued_item),
    .empty    (item_empty)
  );

  // back: pin sequencer, one tick per transaction
  clbs_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item        (queued_item),
    .item_empty  (item_empty),
    .item_pop    (item_pop),
    .res         (engine_res),
    .res_push    (res_push),
    .res_full    (res_full)
  );

  // finished results waiting for the consumer
  clbs_queue #(
    .WIDTH($bits(res_t))
  ) u_res_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .push_data(engine_res),
    .full     (res_full),
    .pop      (pop),
    .pop_data (head_res),
    .empty    (empty)
  );

  assign pin_enable          = head_res.pin_enable;
  assign pin_register_select = head_res.pin_register_select;
  assign pin_read_write      = head_res.pin_read_write;
  assign pin_data_out        = head_res.pin_data_out;
  assign data_drive          = head_res.data_drive;
  assign ready_res           = head_res.ready_res;
  assign rejected            = head_res.rejected;

endmodule
